// ----- design/bba_pkg.sv -----
package bba_pkg;

  // Width of the block map as seen on the result channel.
  localparam int MAP_W = 8 * 2 * 4;

  // Default number of blocks on the disk.
  localparam int BLOCKS_DEF = MAP_W;

  localparam int OPCODE_W = 2;
  localparam int COUNT_W  = 7;
  localparam int BLOCK_W  = 6;
  localparam int USED_W   = 7;

  localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd2;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [COUNT_W-1:0]  count;
    logic [BLOCK_W-1:0]  block;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [USED_W-1:0] used;
    logic [MAP_W-1:0]  block_map;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic scan;
    logic publish;
  } bba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic rsp_held;
  } bba_sts_t;

endpackage

// ----- design/bba_ctrl.sv -----
module bba_ctrl
  import bba_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  bba_sts_t sts,
  output bba_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_SEND = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.scan    = 1'b0;
    cmd.publish = 1'b0;
    req_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        req_stall   = 1'b0;
        cmd.capture = req_valid;
        if (req_valid) begin
          state_next = sts.need_scan ? ST_SCAN : ST_SEND;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_SEND;
        end
      end
      ST_SEND: begin
        if (!sts.rsp_held) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/bba_dp.sv -----
module bba_dp
  import bba_pkg::*;
#(
  parameter int BLOCKS = BLOCKS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  req_t     req,
  input  bba_cmd_t cmd,
  output bba_sts_t sts,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output rsp_t     rsp
);

  localparam int IDX_W = $clog2(BLOCKS);

  logic [BLOCKS-1:0]  used_map;
  logic [USED_W-1:0]  used;
  logic [COUNT_W-1:0] remaining;
  logic [IDX_W-1:0]   scan_idx;
  logic               ok;

  logic               fits;
  logic               free_hit;
  logic [IDX_W-1:0]   free_idx;
  logic               cur_used;

  // An allocate goes ahead only for a nonzero count that the free blocks cover.
  assign fits = (req.count != '0) &&
                ((8'(req.count) + 8'(used)) <= 8'(BLOCKS));

  assign free_idx = req.block[IDX_W-1:0];
  assign free_hit = ({1'b0, req.block} < 7'(BLOCKS)) && used_map[free_idx];
  assign cur_used = used_map[scan_idx];

  assign sts.need_scan = (req.opcode == OP_ALLOC) && fits;
  assign sts.scan_done = !cur_used && (remaining == COUNT_W'(1));
  assign sts.rsp_held  = rsp_valid && rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      used_map <= '0;
      used     <= '0;
    end else if (cmd.capture) begin
      case (req.opcode)
        OP_ALLOC: begin
          ok        <= fits;
          remaining <= req.count;
          scan_idx  <= '0;
        end
        OP_FREE: begin
          ok <= 1'b1;
          if (free_hit) begin
            used_map[free_idx] <= 1'b0;
            used               <= used - USED_W'(1);
          end
        end
        default: begin
          ok <= 1'b1;
        end
      endcase
    end else if (cmd.scan) begin
      scan_idx <= scan_idx + IDX_W'(1);
      if (!cur_used) begin
        used_map[scan_idx] <= 1'b1;
        used               <= used + USED_W'(1);
        remaining          <= remaining - COUNT_W'(1);
      end
    end
  end

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.publish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      rsp.ok        <= ok;
      rsp.used      <= used;
      rsp.block_map <= MAP_W'(used_map);
    end
  end

endmodule

// ----- design/bitmap_block_allocator.sv -----
// Bitmap block allocator: keeps a map of BLOCKS disk blocks, one bit per
// block, in which a set bit means the block is in use.
//
// Request channel (req_valid, req_stall, req): an item carries an opcode,
// a count and a block index. Query changes nothing, allocate marks the
// lowest-numbered free blocks as used when the count is nonzero and enough
// blocks are free, and free clears one block given by its flat index.
// Result channel (rsp_valid, rsp_stall, rsp): one item per request with the
// success flag, the used-block count and the whole map after the command.
//
// Query and free items, and an allocate that cannot go ahead, pass from
// capture straight to their result; a new item is taken only once the
// previous result has been published. An allocate that goes ahead scans
// the single map register one block per cycle from block 0 until the last
// requested block is set, so it walks at most BLOCKS blocks.
//
// Reset clears the map and the used count, and drops any pending result.
// The result sits in an output register; while the receiver stalls, the
// block still accepts one more item, works on it, and then waits with
// req_stall high until the register frees up.
module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int BLOCKS = BLOCKS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  bba_cmd_t cmd;
  bba_sts_t sts;

  // The controller sequences each item: capture, optional scan, publish.
  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the map, the used count and the result register.
  bba_dp #(
    .BLOCKS (BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ----- tb/bitmap_block_allocator_checker.sv -----
module bitmap_block_allocator_checker
  import bba_pkg::*;
#(
  parameter int BLOCKS = BLOCKS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_MAX = 10;

  logic [MAP_W-1:0] held_map;
  rsp_t             awaited_results[$];
  int               fail_total = 0;

  // Applies one command to the local copy of the map and returns the result
  // that the block must produce for it.
  function automatic rsp_t apply_command(input req_t cmd);
    rsp_t             res;
    logic [MAP_W-1:0] disk_mask;
    int               i;
    int               n_used;
    int               want;

    disk_mask = '0;
    for (i = 0; i < BLOCKS; i++) disk_mask[i] = 1'b1;
    n_used = 0;
    for (i = 0; i < MAP_W; i++) n_used += (held_map[i] & disk_mask[i]);
    res.ok = 1'b1;
    if (cmd.opcode == OP_ALLOC) begin
      want = int'(cmd.count);
      if (want == 0 || want > BLOCKS - n_used) begin
        res.ok = 1'b0;
      end else begin
        for (i = 0; i < BLOCKS; i++) begin
          if (want != 0 && !held_map[i]) begin
            held_map[i] = 1'b1;
            want--;
          end
        end
      end
    end else if (cmd.opcode == OP_FREE) begin
      if (int'(cmd.block) < BLOCKS) held_map[cmd.block] = 1'b0;
    end
    held_map = held_map & disk_mask;
    n_used = 0;
    for (i = 0; i < MAP_W; i++) n_used += held_map[i];
    res.used = n_used[USED_W-1:0];
    res.block_map = held_map;
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want_rsp;
    if (rst) begin
      held_map = '0;
      awaited_results.delete();
    end else begin
      // A result can never belong to an item accepted at the same edge, so
      // the result side is handled before the request side.
      if (rsp_valid && !rsp_stall) begin
        if (awaited_results.size() == 0) begin
          if (fail_total < REPORT_MAX)
            $display("%0t ns: result with nothing awaited: ok=%0d used=%0d map=%h",
                     $realtime, rsp.ok, rsp.used, rsp.block_map);
          fail_total++;
        end else begin
          want_rsp = awaited_results.pop_front();
          if (rsp.ok !== want_rsp.ok || rsp.used !== want_rsp.used ||
              rsp.block_map !== want_rsp.block_map) begin
            if (fail_total < REPORT_MAX)
              $display("%0t ns: expected ok=%0d used=%0d map=%h, got ok=%0d used=%0d map=%h",
                       $realtime, want_rsp.ok, want_rsp.used, want_rsp.block_map,
                       rsp.ok, rsp.used, rsp.block_map);
            fail_total++;
          end
        end
      end
      if (req_valid && !req_stall) awaited_results.push_back(apply_command(req));
    end
    errors  <= fail_total;
    pending <= awaited_results.size();
  end

endmodule

// ----- tb/bitmap_block_allocator_test.sv -----
module bitmap_block_allocator_test;
  import bba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The opcode that the block does not define. It must behave like a query.
  localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

  // Width of one request item, used to shape random junk on the payload.
  localparam int REQ_W = $bits(req_t);

  // An allocate may scan the whole map, so the block can stay busy while it
  // does so after an item. The drain at the end allows for that.
  localparam int DRAIN_CYCLES = BLOCKS_DEF + 40;

  // Random items per idling phase. Three phases plus the directed items give
  // roughly fourteen hundred items in all.
  localparam int PHASE_ITEMS = 460;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int errors;
  int pending;

  // Percentages that shape the idling of both sides. The sender skips a
  // cycle with probability send_idle_pct, the receiver stalls with
  // probability recv_stall_pct.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  bitmap_block_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // The checker sits beside the block, watches both channels, predicts every
  // result and reports how many failures it has seen and how many results
  // are still outstanding.
  bitmap_block_allocator_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending)
  );

  always #10 clk = ~clk;

  // The receiver decides afresh at every edge whether to stall.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offers one item and returns right after the edge at which it is taken.
  // Idle cycles come first and carry random junk on the payload, which the
  // block must ignore since valid is low. Valid is not lowered between two
  // back-to-back items, so it gets only one assignment per time step.
  task automatic send_item(input logic [OPCODE_W-1:0] op, input int cnt, input int blk);
    req_t item;
    item.opcode = op;
    item.count  = cnt[COUNT_W-1:0];
    item.block  = blk[BLOCK_W-1:0];
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      req       <= REQ_W'($urandom);
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Picks an allocate count. Most counts are small so that the map keeps
  // holes; a few are zero, the whole disk, or any value the field can hold.
  function automatic int pick_count();
    int sel;
    sel = $urandom_range(19);
    if (sel == 0) return 0;
    if (sel == 1) return BLOCKS_DEF;
    if (sel == 2) return $urandom_range(127);
    return $urandom_range(5) + 1;
  endfunction

  // Random traffic in episodes. Each episode favors allocates to a different
  // degree so the map swings between nearly empty and full. Now and then a
  // run of consecutive blocks is freed, which opens holes that the
  // lowest-first search must fill in order.
  task automatic run_random(input int n_items);
    int sent;
    int alloc_pct;
    int first;
    int span;
    int pick;
    int i;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        first = $urandom_range(63);
        span  = $urandom_range(28) + 4;
        for (i = 0; i < span && sent < n_items; i++) begin
          send_item(OP_FREE, $urandom_range(127), (first + i) % BLOCKS_DEF);
          sent++;
        end
      end else begin
        alloc_pct = 15 * ($urandom_range(2) + 1);
        for (i = 0; i < 30 && sent < n_items; i++) begin
          pick = $urandom_range(99);
          if (pick < alloc_pct)
            send_item(OP_ALLOC, pick_count(), $urandom_range(63));
          else if (pick < alloc_pct + 8)
            send_item(OP_QUERY, $urandom_range(127), $urandom_range(63));
          else if (pick < alloc_pct + 12)
            send_item(OP_SPARE, $urandom_range(127), $urandom_range(63));
          else
            send_item(OP_FREE, $urandom_range(127), $urandom_range(63));
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // The first phase has a sender that idles a little and a receiver that
    // stalls often, so the result register backs up.
    send_idle_pct  = 20;
    recv_stall_pct = 60;

    // Directed items. The map starts empty.
    send_item(OP_QUERY, 127, 63);    // junk in unused fields is ignored
    send_item(OP_ALLOC, 0, 0);       // zero count fails
    send_item(OP_FREE, 0, 0);        // freeing a free block
    send_item(OP_ALLOC, 65, 0);      // more than the disk holds
    send_item(OP_ALLOC, 127, 63);    // largest count the field can carry
    send_item(OP_ALLOC, 64, 0);      // whole disk at once
    send_item(OP_ALLOC, 1, 0);       // no free block left
    send_item(OP_SPARE, 127, 63);    // undefined opcode acts as a query
    send_item(OP_FREE, 0, 63);
    send_item(OP_FREE, 0, 0);
    send_item(OP_FREE, 0, 31);
    send_item(OP_ALLOC, 3, 0);       // exactly as many as are free
    send_item(OP_FREE, 0, 42);
    send_item(OP_FREE, 0, 42);       // second free of the same block
    send_item(OP_FREE, 0, 7);
    send_item(OP_ALLOC, 3, 0);       // one more than is free
    send_item(OP_ALLOC, 1, 0);       // lowest hole first
    send_item(OP_ALLOC, 1, 0);
    send_item(OP_QUERY, 0, 0);
    send_item(OP_ALLOC, 64, 0);      // full map, large request fails

    run_random(PHASE_ITEMS);

    // The second phase turns the pattern around: a slow sender and a
    // receiver that rarely stalls.
    send_idle_pct  = 60;
    recv_stall_pct = 20;
    run_random(PHASE_ITEMS);

    // The last phase runs at full speed on both sides.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(PHASE_ITEMS);

    req_valid <= 1'b0;

    // The checker's counts are registered, so the bench waits on the clock
    // before it reads them.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Safety net. The slowest correct run stays far below this.
  initial begin
    #15_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/bba_pkg.sv
design/bba_ctrl.sv
design/bba_dp.sv
design/bitmap_block_allocator.sv
tb/bitmap_block_allocator_checker.sv
tb/bitmap_block_allocator_test.sv
